[hdl/dpt_pkg.sv]
// Shared types and constants for the divider and programmable timer.
// No dependencies; used by dpt_timer and divider_and_programmable_timer.
`timescale 1ns / 1ps

package dpt_pkg;

    typedef logic [1:0] t_opcode;
    typedef logic [1:0] t_reg_sel;

    localparam t_opcode OP_TICK   = 2'd0;
    localparam t_opcode OP_READ   = 2'd1;
    localparam t_opcode OP_WRITE  = 2'd2;
    // Opcode 3 is unused: no state change, all-zero result.
    localparam t_opcode OP_UNUSED = 2'd3;

    localparam t_reg_sel SEL_DIVIDER = 2'd0;
    localparam t_reg_sel SEL_COUNTER = 2'd1;
    localparam t_reg_sel SEL_MODULO  = 2'd2;
    localparam t_reg_sel SEL_CONTROL = 2'd3;

    localparam int unsigned CTRL_ENABLE_BIT = 2;

    // Timer rate codes held in control bits 1:0.
    localparam logic [1:0] RATE_256 = 2'd0;
    localparam logic [1:0] RATE_4   = 2'd1;
    localparam logic [1:0] RATE_16  = 2'd2;
    localparam logic [1:0] RATE_64  = 2'd3;

    typedef struct packed {
        t_opcode    opcode;
        t_reg_sel   reg_select;
        logic [7:0] write_data;
    } t_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       timer_irq;
    } t_result;

endpackage

[hdl/dpt_timer.sv]
// Timer state registers and the single-pass tick / read / write logic.
// Depends on dpt_pkg.
`timescale 1ns / 1ps

module dpt_timer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  dpt_pkg::t_item  i_item,
    output dpt_pkg::t_result o_result
);

    logic [7:0] r_cycle, n_cycle;
    logic [7:0] r_divider, n_divider;
    logic [7:0] r_counter, n_counter;
    logic [7:0] r_modulo, n_modulo;
    logic [7:0] r_control, n_control;

    logic [7:0] cycle_inc;
    logic       rate_hit;
    logic [8:0] counter_sum;

    assign cycle_inc   = r_cycle + 8'd1;
    assign counter_sum = {1'b0, r_counter} + 9'd1;

    always_comb begin
        case (r_control[1:0])
            dpt_pkg::RATE_256: rate_hit = (cycle_inc == 8'd0);
            dpt_pkg::RATE_4:   rate_hit = (cycle_inc[1:0] == 2'd0);
            dpt_pkg::RATE_16:  rate_hit = (cycle_inc[3:0] == 4'd0);
            dpt_pkg::RATE_64:  rate_hit = (cycle_inc[5:0] == 6'd0);
            default:           rate_hit = 1'b0;
        endcase
    end

    always_comb begin
        n_cycle   = r_cycle;
        n_divider = r_divider;
        n_counter = r_counter;
        n_modulo  = r_modulo;
        n_control = r_control;
        o_result  = '0;
        unique case (i_item.opcode)
            dpt_pkg::OP_TICK: begin
                n_cycle = cycle_inc;
                if (cycle_inc[5:0] == 6'd0) begin
                    n_divider = r_divider + 8'd1;
                end
                if (r_control[dpt_pkg::CTRL_ENABLE_BIT] && rate_hit) begin
                    if (counter_sum[8]) begin
                        n_counter          = r_modulo;
                        o_result.timer_irq = 1'b1;
                    end else begin
                        n_counter = counter_sum[7:0];
                    end
                end
            end
            dpt_pkg::OP_READ: begin
                unique case (i_item.reg_select)
                    dpt_pkg::SEL_DIVIDER: o_result.read_data = r_divider;
                    dpt_pkg::SEL_COUNTER: o_result.read_data = r_counter;
                    dpt_pkg::SEL_MODULO:  o_result.read_data = r_modulo;
                    default:              o_result.read_data = r_control;
                endcase
            end
            dpt_pkg::OP_WRITE: begin
                unique case (i_item.reg_select)
                    dpt_pkg::SEL_DIVIDER: n_divider = 8'd0;
                    dpt_pkg::SEL_COUNTER: n_counter = i_item.write_data;
                    dpt_pkg::SEL_MODULO:  n_modulo  = i_item.write_data;
                    default:              n_control = i_item.write_data;
                endcase
            end
            default: begin
                // Unused opcode: no state change, all-zero result.
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cycle   <= '0;
            r_divider <= '0;
            r_counter <= '0;
            r_modulo  <= '0;
            r_control <= '0;
        end else if (i_en) begin
            r_cycle   <= n_cycle;
            r_divider <= n_divider;
            r_counter <= n_counter;
            r_modulo  <= n_modulo;
            r_control <= n_control;
        end
    end

endmodule

[hdl/divider_and_programmable_timer.sv]
// Top level of the divider and programmable timer: stream ports, input and
// result registers around dpt_timer. Depends on dpt_pkg and dpt_timer.
`timescale 1ns / 1ps

// Usage
// The slave channel carries one item per transfer: a machine-cycle tick, a
// register read or a register write. tuser selects the operation and the
// register, tdata carries the byte to write. The master channel returns
// exactly one result per item, in order: the byte read (zero unless the
// item was a read) in tdata and the timer interrupt flag in tuser.
// The result is registered: the item waits in the input register, then
// passes through the timer logic into the result register. Throughput is
// one item per cycle while the receiver keeps tready high; the timer state
// updates as the item leaves the input register, so back-to-back items
// see each other's effects exactly as if processed one at a time.
// A synchronous active-low reset clears the timer registers and empties
// both pipeline registers. When the receiver holds tready low, the result
// register keeps its transfer, the input register fills behind it, and
// then the slave tready drops until the master side moves again.
module divider_and_programmable_timer (
    input  logic       i_clk,
    input  logic       i_rst_n,

    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] write_data
    input  logic [3:0] s_axis_tuser,   // [1:0] opcode, [3:2] reg_select

    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] read_data
    output logic [0:0] m_axis_tuser    // [0] timer_irq
);

    logic             r_in_valid;
    dpt_pkg::t_item   r_in_item;
    logic             r_out_valid;
    dpt_pkg::t_result r_out_result;

    dpt_pkg::t_result result;
    logic             advance;

    // The item in the input register moves on whenever the result register
    // is empty or its transfer completes this cycle.
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    dpt_timer u_timer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_item   (r_in_item),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_item.opcode     <= s_axis_tuser[1:0];
            r_in_item.reg_select <= s_axis_tuser[3:2];
            r_in_item.write_data <= s_axis_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_result <= result;
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_result.read_data;
    assign m_axis_tuser[0] = r_out_result.timer_irq;

endmodule
